// ===== hdl/iqd5_pkg.sv =====
package iqd5_pkg;

    localparam int MAX_SAMPLES  = 1024;
    localparam int CORDIC_STEPS = 16;
    localparam int SUM_W        = 38;
    localparam int CNT_W        = $clog2(MAX_SAMPLES + 1);
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int VEC_W        = SUM_W + 4;
    localparam int ANG_W        = 18;
    localparam int PI_Q13       = 25736;
    localparam int INV_GAIN_Q16 = 39797;
    localparam int HALF_W       = 20;
    localparam int NUM_W        = 57;
    localparam int DIV_W        = NUM_W - 27;
    localparam int DIV_CNT_W    = $clog2(DIV_W + 1);

    typedef struct packed {
        logic signed [SUM_W-1:0] i_sum;
        logic signed [SUM_W-1:0] q_sum;
        logic [CNT_W-1:0]        count;
        logic                    overrun;
    } blk_t;

    function automatic logic signed [16:0] cos_coef(input logic [2:0] t);
        logic signed [16:0] c;
        unique case (t)
            3'd1:    c = 17'sd10125;
            3'd2:    c = -17'sd26509;
            3'd3:    c = -17'sd26509;
            3'd4:    c = 17'sd10125;
            default: c = 17'sd32768;
        endcase
        return c;
    endfunction

    function automatic logic signed [16:0] sin_coef(input logic [2:0] t);
        logic signed [16:0] c;
        unique case (t)
            3'd1:    c = 17'sd31166;
            3'd2:    c = 17'sd19261;
            3'd3:    c = -17'sd19261;
            3'd4:    c = -17'sd31166;
            default: c = 17'sd0;
        endcase
        return c;
    endfunction

    function automatic logic [12:0] atan_q13(input logic [STEP_W-1:0] i);
        logic [12:0] a;
        unique case (i)
            0:       a = 13'd6434;
            1:       a = 13'd3798;
            2:       a = 13'd2007;
            3:       a = 13'd1019;
            4:       a = 13'd511;
            5:       a = 13'd256;
            6:       a = 13'd128;
            7:       a = 13'd64;
            8:       a = 13'd32;
            9:       a = 13'd16;
            10:      a = 13'd8;
            11:      a = 13'd4;
            12:      a = 13'd2;
            13:      a = 13'd1;
            default: a = 13'd0;
        endcase
        return a;
    endfunction

endpackage

// ===== hdl/iqd5_front.sv =====
module iqd5_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [11:0]         s_sample,
    input  logic                s_last_sample,
    output logic                push,
    output iqd5_pkg::blk_t      push_data,
    input  logic                q_full
);
    import iqd5_pkg::*;

    logic signed [SUM_W-1:0] i_reg, i_next, q_reg, q_next;
    logic [2:0]              pos_reg, pos_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    drop_reg, drop_next;
    logic signed [12:0]      sd;
    logic signed [29:0]      prod_i, prod_q;
    logic                    acc;

    assign s_ready = !q_full;
    assign acc     = s_valid && s_ready;
    assign sd      = $signed({1'b0, s_sample}) - 13'sd2048;
    assign prod_i  = sd * cos_coef(pos_reg);
    assign prod_q  = sd * sin_coef(pos_reg);

    always_comb begin
        i_next    = i_reg;
        q_next    = q_reg;
        pos_next  = pos_reg;
        cnt_next  = cnt_reg;
        drop_next = drop_reg;
        if (acc) begin
            if (cnt_reg < CNT_W'(MAX_SAMPLES)) begin
                i_next   = i_reg + SUM_W'(prod_i);
                q_next   = q_reg + SUM_W'(prod_q);
                pos_next = (pos_reg == 3'd4) ? 3'd0 : pos_reg + 3'd1;
                cnt_next = cnt_reg + CNT_W'(1);
            end else begin
                drop_next = 1'b1;
            end
        end
    end

    assign push              = acc && s_last_sample;
    assign push_data.i_sum   = i_next;
    assign push_data.q_sum   = q_next;
    assign push_data.count   = cnt_next;
    assign push_data.overrun = drop_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || push) begin
            i_reg    <= '0;
            q_reg    <= '0;
            pos_reg  <= '0;
            cnt_reg  <= '0;
            drop_reg <= 1'b0;
        end else begin
            i_reg    <= i_next;
            q_reg    <= q_next;
            pos_reg  <= pos_next;
            cnt_reg  <= cnt_next;
            drop_reg <= drop_next;
        end
    end
endmodule

// ===== hdl/iqd5_queue.sv =====
module iqd5_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  iqd5_pkg::blk_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output iqd5_pkg::blk_t head
);
    import iqd5_pkg::*;

    blk_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign full    = cnt_reg[1];
    assign q_valid = cnt_reg != 2'd0;
    assign head    = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) wp_reg <= !wp_reg;
            if (pop)  rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

// ===== hdl/iqd5_back.sv =====
module iqd5_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    input  iqd5_pkg::blk_t head,
    output logic           pop,
    output logic           m_valid,
    input  logic           m_ready,
    output logic [15:0]    m_magnitude,
    output logic signed [15:0] m_phase,
    output logic           m_overrun
);
    import iqd5_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CORD = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_ADD  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_DONE = 3'd5;

    logic [2:0]              st_reg;
    logic signed [VEC_W-1:0] x_reg, y_reg, dx, dy, xs, ys;
    logic signed [ANG_W-1:0] z_reg, z0, zc;
    logic [STEP_W-1:0]       it_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    ovr_reg, m_valid_reg;
    logic [HALF_W+15:0]      plo_reg, phi_reg;
    logic [NUM_W-1:0]        num;
    logic [DIV_W-1:0]        dvd_reg, quo_reg;
    logic [CNT_W:0]          rem_reg, rem_sh;
    logic [DIV_CNT_W-1:0]    dc_reg;
    logic [15:0]             mag_reg, mag_out;
    logic signed [15:0]      ph_reg, ph_out;
    logic                    zero_blk;

    assign pop      = (st_reg == ST_IDLE) && q_valid;
    assign zero_blk = (head.i_sum == '0) && (head.q_sum == '0);
    assign dx       = y_reg >>> it_reg;
    assign dy       = x_reg >>> it_reg;
    assign xs       = VEC_W'(head.i_sum);
    assign ys       = VEC_W'(head.q_sum);
    assign z0       = (head.q_sum >= 0) ? ANG_W'(PI_Q13) : -ANG_W'(PI_Q13);
    assign num      = {phi_reg, {HALF_W{1'b0}}} + NUM_W'(plo_reg)
                    + (NUM_W'(cnt_reg) << 26);
    assign rem_sh   = {rem_reg[CNT_W-1:0], dvd_reg[DIV_W-1]};
    assign zc       = (z_reg > ANG_W'(PI_Q13)) ? ANG_W'(PI_Q13) :
                      (z_reg < -ANG_W'(PI_Q13)) ? -ANG_W'(PI_Q13) : z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
            dc_reg <= '0;
        end else begin
            unique case (st_reg)
                ST_IDLE: if (q_valid) begin
                    cnt_reg <= head.count;
                    ovr_reg <= head.overrun;
                    it_reg  <= '0;
                    if (zero_blk) begin
                        mag_reg <= '0;
                        ph_reg  <= '0;
                        st_reg  <= ST_DONE;
                    end else begin
                        if (head.i_sum < 0) begin
                            x_reg <= -xs;
                            y_reg <= -ys;
                            z_reg <= z0;
                        end else begin
                            x_reg <= xs;
                            y_reg <= ys;
                            z_reg <= '0;
                        end
                        st_reg <= ST_CORD;
                    end
                end
                ST_CORD: begin
                    if (y_reg >= 0) begin
                        x_reg <= x_reg + dx;
                        y_reg <= y_reg - dy;
                        z_reg <= z_reg + ANG_W'(atan_q13(it_reg));
                    end else begin
                        x_reg <= x_reg - dx;
                        y_reg <= y_reg + dy;
                        z_reg <= z_reg - ANG_W'(atan_q13(it_reg));
                    end
                    it_reg <= it_reg + STEP_W'(1);
                    if (it_reg == STEP_W'(CORDIC_STEPS - 1)) st_reg <= ST_MUL;
                end
                ST_MUL: begin
                    // split the gain correction into two narrow products
                    ph_reg <= 16'(zc);
                    if (x_reg < 0) begin
                        plo_reg <= '0;
                        phi_reg <= '0;
                    end else begin
                        plo_reg <= x_reg[HALF_W-1:0] * 16'(INV_GAIN_Q16);
                        phi_reg <= x_reg[2*HALF_W-1:HALF_W] * 16'(INV_GAIN_Q16);
                    end
                    st_reg <= ST_ADD;
                end
                ST_ADD: begin
                    dvd_reg <= num[NUM_W-1:27];
                    rem_reg <= '0;
                    quo_reg <= '0;
                    dc_reg  <= '0;
                    st_reg  <= ST_DIV;
                end
                ST_DIV: begin
                    // restoring divide by count, one quotient bit per cycle
                    dvd_reg <= dvd_reg << 1;
                    if (rem_sh >= {1'b0, cnt_reg}) begin
                        rem_reg <= rem_sh - {1'b0, cnt_reg};
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        quo_reg <= {quo_reg[DIV_W-2:0], 1'b0};
                    end
                    dc_reg <= dc_reg + DIV_CNT_W'(1);
                    if (dc_reg == DIV_CNT_W'(DIV_W - 1)) st_reg <= ST_DONE;
                end
                ST_DONE: begin
                    if (dc_reg == DIV_CNT_W'(DIV_W))
                        mag_reg <= (quo_reg > DIV_W'(65535)) ? 16'hFFFF : quo_reg[15:0];
                    dc_reg <= '0;
                    if (!m_valid_reg || m_ready) st_reg <= ST_IDLE;
                end
                default: st_reg <= ST_IDLE;
            endcase
        end
    end

    // DONE holds one extra look at the quotient before handing off
    assign mag_out = (dc_reg == DIV_CNT_W'(DIV_W))
                   ? ((quo_reg > DIV_W'(65535)) ? 16'hFFFF : quo_reg[15:0]) : mag_reg;
    assign ph_out  = ph_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (st_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
            m_magnitude <= mag_out;
            m_phase     <= ph_out;
            m_overrun   <= ovr_reg;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
endmodule

// ===== hdl/iq_demodulator_five_point_core.sv =====
// Single-bin I/Q demodulator over five-point cosine/sine tables. Samples are
// taken one per cycle while s_ready is high; the front accumulates them and,
// on the beat marked last, hands the block's sums to a two-entry queue. The
// back turns each block into magnitude (Q12.4) and phase (Q3.13) by 16 CORDIC
// iterations, a gain product in two halves, a 30-bit divide by the sample
// count and a hand-off, and takes the next block only once idle. The input
// stalls only when two finished blocks are waiting behind one in the back end.
module iq_demodulator_five_point_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [11:0]        s_sample,
    input  logic               s_last_sample,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_magnitude,
    output logic signed [15:0] m_phase,
    output logic               m_overrun
);
    import iqd5_pkg::*;

    logic push, full, pop, q_valid;
    blk_t push_data, head;

    iqd5_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_sample, .s_last_sample,
        .push, .push_data, .q_full(full)
    );

    iqd5_queue u_queue (
        .aclk, .aresetn, .push, .push_data, .full, .pop, .q_valid, .head
    );

    iqd5_back u_back (
        .aclk, .aresetn, .q_valid, .head, .pop,
        .m_valid, .m_ready, .m_magnitude, .m_phase, .m_overrun
    );

`ifndef SYNTHESIS
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_phase <= 16'sd25736 && m_phase >= -16'sd25736))
        else $error("phase out of range");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push)
        else $error("push into full queue");
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");
`endif
endmodule
